// ===== src/sql_statement_tokenizer_top_macros.svh =====
// Assertion macros shared by the tokenizer RTL.
`ifndef SQL_STATEMENT_TOKENIZER_TOP_MACROS_SVH
`define SQL_STATEMENT_TOKENIZER_TOP_MACROS_SVH

// Antecedent holds in a cycle, consequent must hold in the same cycle.
`define STT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent holds in a cycle, consequent must hold in the following cycle.
`define STT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/stt_pkg.sv =====
// Shared types and token codes for the SQL statement tokenizer.
package stt_pkg;

  localparam int POS_BITS_DEFAULT  = 16;
  localparam int KEY_CHARS_DEFAULT = 8;

  localparam int OUT_POS_BITS = 16;
  localparam int RES_DEPTH    = 4;
  localparam int RES_PTR_W    = $clog2(RES_DEPTH);
  localparam int RES_CNT_W    = $clog2(RES_DEPTH + 1);

  localparam logic [4:0] KIND_IDENT  = 5'd16;
  localparam logic [4:0] KIND_INT    = 5'd17;
  localparam logic [4:0] KIND_STR    = 5'd18;
  localparam logic [4:0] KIND_STAR   = 5'd19;
  localparam logic [4:0] KIND_COMMA  = 5'd20;
  localparam logic [4:0] KIND_LPAREN = 5'd21;
  localparam logic [4:0] KIND_RPAREN = 5'd22;
  localparam logic [4:0] KIND_EQ     = 5'd23;
  localparam logic [4:0] KIND_LT     = 5'd24;
  localparam logic [4:0] KIND_GT     = 5'd25;
  localparam logic [4:0] KIND_END    = 5'd26;
  localparam logic [4:0] KIND_ERR    = 5'd27;

  localparam logic [1:0] CAUSE_NONE     = 2'd0;
  localparam logic [1:0] CAUSE_UNEXPECT = 2'd1;
  localparam logic [1:0] CAUSE_UNTERM   = 2'd2;
  localparam logic [1:0] CAUSE_TOO_LONG = 2'd3;

  typedef struct packed {
    logic [4:0]              kind;
    logic [OUT_POS_BITS-1:0] start_pos;
    logic [OUT_POS_BITS-1:0] span_len;
    logic [1:0]              error_cause;
    logic                    last_of_item;
  } result_t;

  // Results caused by one item, already packed to the front.
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } res_pair_t;

  typedef struct packed {
    logic [RES_CNT_W-1:0] count;
    logic                 room;
  } fifo_status_t;

endpackage

// ===== src/stt_lexer.sv =====
// Lexer state and per-byte token decisions for the SQL statement tokenizer.
module stt_lexer #(
  parameter int POS_BITS  = stt_pkg::POS_BITS_DEFAULT,
  parameter int KEY_CHARS = stt_pkg::KEY_CHARS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  logic               func,
  input  logic [7:0]         char_in,
  output stt_pkg::res_pair_t results
);

  localparam int KW_CHARS = 8;
  localparam int WL_W     = $clog2(KEY_CHARS + 2);
  localparam int WIDE_W   = (POS_BITS > stt_pkg::OUT_POS_BITS) ? POS_BITS
                                                               : stt_pkg::OUT_POS_BITS;

  localparam logic [63:0] KW_TEXT [16] = '{
    "create", "database", "drop", "use", "table", "primary", "insert", "values",
    "select", "from", "where", "delete", "update", "set", "int", "string"
  };
  localparam logic [3:0] KW_LEN [16] = '{
    4'd6, 4'd8, 4'd4, 4'd3, 4'd5, 4'd7, 4'd6, 4'd6,
    4'd6, 4'd4, 4'd5, 4'd6, 4'd6, 4'd3, 4'd3, 4'd6
  };

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_WORD, MODE_NUM, MODE_MINUS, MODE_STR, MODE_ERR
  } mode_t;

  mode_t               mode, mode_next;
  logic [POS_BITS-1:0] byte_count, byte_count_next;
  logic [POS_BITS-1:0] token_start, token_start_next;
  logic [WL_W-1:0]     word_letters, word_letters_next;
  logic [7:0]          letters [KW_CHARS];
  logic                letter_we;
  logic [2:0]          letter_idx;

  logic                a_v, b_v;
  stt_pkg::result_t    a_res, b_res;
  logic [4:0]          word_kind;
  logic                is_lower, is_digit, is_space;
  logic [POS_BITS-1:0] tok_len;

  function automatic logic [stt_pkg::OUT_POS_BITS-1:0] to_out(input logic [POS_BITS-1:0] v);
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(v);
    return w[stt_pkg::OUT_POS_BITS-1:0];
  endfunction

  function automatic stt_pkg::result_t mk(input logic [4:0] kind,
                                          input logic [POS_BITS-1:0] pos,
                                          input logic [POS_BITS-1:0] len,
                                          input logic [1:0] cause);
    stt_pkg::result_t r;
    r.kind         = kind;
    r.start_pos    = to_out(pos);
    r.span_len     = to_out(len);
    r.error_cause  = cause;
    r.last_of_item = 1'b0;
    return r;
  endfunction

  assign is_lower = (char_in >= "a") && (char_in <= "z");
  assign is_digit = (char_in >= "0") && (char_in <= "9");
  assign is_space = (char_in == " ") || (char_in == 8'h09) || (char_in == 8'h0a) ||
                    (char_in == 8'h0d);
  assign tok_len  = byte_count - token_start;

  // The lowest keyword index wins; a word longer than any keyword never matches.
  always_comb begin
    logic hit;
    word_kind = stt_pkg::KIND_IDENT;
    for (int k = 15; k >= 0; k--) begin
      hit = (WL_W'(KW_LEN[k]) == word_letters);
      for (int i = 0; i < KW_CHARS; i++) begin
        if (4'(i) < KW_LEN[k]) begin
          hit = hit && (letters[i] == KW_TEXT[k][(KW_LEN[k] - 4'(i) - 4'd1) * 8 +: 8]);
        end
      end
      if (hit) begin
        word_kind = 5'(k);
      end
    end
  end

  always_comb begin
    logic start_req;
    mode_next         = mode;
    byte_count_next   = byte_count;
    token_start_next  = token_start;
    word_letters_next = word_letters;
    letter_we         = 1'b0;
    letter_idx        = word_letters[2:0];
    a_v               = 1'b0;
    b_v               = 1'b0;
    a_res             = mk(stt_pkg::KIND_ERR, byte_count, '0, stt_pkg::CAUSE_NONE);
    b_res             = a_res;
    start_req         = 1'b0;

    if (fire) begin
      if (func) begin
        case (mode)
          MODE_WORD: begin
            a_v   = 1'b1;
            a_res = mk(word_kind, token_start, tok_len, stt_pkg::CAUSE_NONE);
          end
          MODE_NUM: begin
            a_v   = 1'b1;
            a_res = mk(stt_pkg::KIND_INT, token_start, tok_len, stt_pkg::CAUSE_NONE);
          end
          MODE_MINUS: begin
            a_v   = 1'b1;
            a_res = mk(stt_pkg::KIND_ERR, token_start, '0, stt_pkg::CAUSE_UNEXPECT);
          end
          MODE_STR: begin
            a_v   = 1'b1;
            a_res = mk(stt_pkg::KIND_ERR, token_start, '0, stt_pkg::CAUSE_UNTERM);
          end
          default: begin
          end
        endcase
        // A reported error stands in for the end token.
        if (mode != MODE_ERR && mode != MODE_MINUS && mode != MODE_STR) begin
          b_v   = 1'b1;
          b_res = mk(stt_pkg::KIND_END, byte_count, '0, stt_pkg::CAUSE_NONE);
        end
        mode_next        = MODE_IDLE;
        byte_count_next  = '0;
        token_start_next = '0;
      end else if (mode != MODE_ERR) begin
        if (&byte_count) begin
          a_v       = 1'b1;
          a_res     = mk(stt_pkg::KIND_ERR, byte_count, '0, stt_pkg::CAUSE_TOO_LONG);
          mode_next = MODE_ERR;
        end else begin
          case (mode)
            MODE_WORD: begin
              if (is_lower) begin
                if (word_letters < WL_W'(KW_CHARS)) begin
                  letter_we = 1'b1;
                end
                if (word_letters <= WL_W'(KEY_CHARS)) begin
                  word_letters_next = word_letters + 1'b1;
                end
              end else begin
                a_v       = 1'b1;
                a_res     = mk(word_kind, token_start, tok_len, stt_pkg::CAUSE_NONE);
                start_req = 1'b1;
              end
            end
            MODE_NUM: begin
              if (!is_digit) begin
                a_v       = 1'b1;
                a_res     = mk(stt_pkg::KIND_INT, token_start, tok_len, stt_pkg::CAUSE_NONE);
                start_req = 1'b1;
              end
            end
            MODE_MINUS: begin
              if (is_digit) begin
                mode_next = MODE_NUM;
              end else begin
                a_v       = 1'b1;
                a_res     = mk(stt_pkg::KIND_ERR, token_start, '0, stt_pkg::CAUSE_UNEXPECT);
                mode_next = MODE_ERR;
              end
            end
            MODE_STR: begin
              if (char_in == "\"") begin
                a_v       = 1'b1;
                a_res     = mk(stt_pkg::KIND_STR, token_start, tok_len - 1'b1,
                               stt_pkg::CAUSE_NONE);
                mode_next = MODE_IDLE;
              end
            end
            default: begin
              start_req = 1'b1;
            end
          endcase

          // The byte that ends one token may open or complete the next.
          if (start_req) begin
            token_start_next = byte_count;
            mode_next        = MODE_IDLE;
            if (is_space) begin
              mode_next = MODE_IDLE;
            end else if (is_lower) begin
              letter_we         = 1'b1;
              letter_idx        = 3'd0;
              word_letters_next = WL_W'(1);
              mode_next         = MODE_WORD;
            end else if (is_digit) begin
              mode_next = MODE_NUM;
            end else if (char_in == "-") begin
              mode_next = MODE_MINUS;
            end else if (char_in == "\"") begin
              mode_next = MODE_STR;
            end else begin
              b_v = 1'b1;
              case (char_in)
                "*": b_res = mk(stt_pkg::KIND_STAR, byte_count, POS_BITS'(1),
                                stt_pkg::CAUSE_NONE);
                ",": b_res = mk(stt_pkg::KIND_COMMA, byte_count, POS_BITS'(1),
                                stt_pkg::CAUSE_NONE);
                "(": b_res = mk(stt_pkg::KIND_LPAREN, byte_count, POS_BITS'(1),
                                stt_pkg::CAUSE_NONE);
                ")": b_res = mk(stt_pkg::KIND_RPAREN, byte_count, POS_BITS'(1),
                                stt_pkg::CAUSE_NONE);
                "=": b_res = mk(stt_pkg::KIND_EQ, byte_count, POS_BITS'(1),
                                stt_pkg::CAUSE_NONE);
                "<": b_res = mk(stt_pkg::KIND_LT, byte_count, POS_BITS'(1),
                                stt_pkg::CAUSE_NONE);
                ">": b_res = mk(stt_pkg::KIND_GT, byte_count, POS_BITS'(1),
                                stt_pkg::CAUSE_NONE);
                default: begin
                  b_res     = mk(stt_pkg::KIND_ERR, byte_count, '0, stt_pkg::CAUSE_UNEXPECT);
                  mode_next = MODE_ERR;
                end
              endcase
            end
          end
          byte_count_next = byte_count + 1'b1;
        end
      end
    end
  end

  // Pack the results to the front and mark the final one of the item.
  always_comb begin
    results.n  = {1'b0, a_v} + {1'b0, b_v};
    results.r0 = a_v ? a_res : b_res;
    results.r1 = b_res;
    if (a_v && b_v) begin
      results.r1.last_of_item = 1'b1;
    end else begin
      results.r0.last_of_item = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      byte_count  <= '0;
      token_start <= '0;
    end else begin
      mode        <= mode_next;
      byte_count  <= byte_count_next;
      token_start <= token_start_next;
    end
  end

  always_ff @(posedge clk) begin
    word_letters <= word_letters_next;
    if (letter_we) begin
      letters[letter_idx] <= char_in;
    end
  end

endmodule

// ===== src/stt_result_fifo.sv =====
// Small result queue that takes up to two tokens a cycle and gives one.
module stt_result_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  stt_pkg::res_pair_t    push,
  input  logic                  pop,
  output stt_pkg::result_t      head,
  output stt_pkg::fifo_status_t status
);

  stt_pkg::result_t                entries [stt_pkg::RES_DEPTH];
  logic [stt_pkg::RES_PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [stt_pkg::RES_CNT_W-1:0]   count;
  logic [stt_pkg::RES_PTR_W-1:0]   wr_ptr_plus;

  assign wr_ptr_plus  = wr_ptr + 1'b1;
  assign head         = entries[rd_ptr];
  assign status.count = count;
  // Room for a full pair, so an item never has to be split.
  assign status.room  = count <= stt_pkg::RES_CNT_W'(stt_pkg::RES_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + stt_pkg::RES_PTR_W'(push.n);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + stt_pkg::RES_CNT_W'(push.n) - stt_pkg::RES_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      entries[wr_ptr] <= push.r0;
    end
    if (push.n == 2'd2) begin
      entries[wr_ptr_plus] <= push.r1;
    end
  end

endmodule

// ===== src/sql_statement_tokenizer_top.sv =====
// Top level of the SQL statement tokenizer: input register, lexer and result queue.
//
//   channel  direction  payload                                          beat
//   in       to block   func, char_in                                    one byte or end mark
//   out      from block kind, start_pos, span_len, error_cause, last_of_item  one token
//
// A beat is held in the input register until the queue has room, decided by the lexer and its
// tokens written into a four-entry result queue; a token passes the input register and
// the queue register before it appears. One input beat is taken per cycle while the queue has room
// for two tokens, so output stalls and two-token beats set the sustained rate.
// Synchronous reset clears the lexer mode, position counters and queue pointers.
`include "sql_statement_tokenizer_top_macros.svh"

module sql_statement_tokenizer_top #(
  parameter int POS_BITS  = stt_pkg::POS_BITS_DEFAULT,
  parameter int KEY_CHARS = stt_pkg::KEY_CHARS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [7:0]  char_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  kind,
  output logic [15:0] start_pos,
  output logic [15:0] span_len,
  output logic [1:0]  error_cause,
  output logic        last_of_item
);

  logic                  item_valid, item_valid_next;
  logic                  item_func;
  logic [7:0]            item_char;
  logic                  advance;
  logic                  in_accept;
  logic                  pop;
  stt_pkg::res_pair_t    results;
  stt_pkg::result_t      head;
  stt_pkg::fifo_status_t fifo_status;

  assign advance         = item_valid && fifo_status.room;
  assign in_stall        = item_valid && !fifo_status.room;
  assign in_accept       = in_valid && !in_stall;
  assign item_valid_next = in_accept || (item_valid && !advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= item_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_func <= func;
      item_char <= char_in;
    end
  end

  stt_lexer #(
    .POS_BITS  (POS_BITS),
    .KEY_CHARS (KEY_CHARS)
  ) u_lexer (
    .clk     (clk),
    .rst     (rst),
    .fire    (advance),
    .func    (item_func),
    .char_in (item_char),
    .results (results)
  );

  stt_result_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (results),
    .pop    (pop),
    .head   (head),
    .status (fifo_status)
  );

  assign out_valid    = fifo_status.count != '0;
  assign pop          = out_valid && !out_stall;
  assign kind         = head.kind;
  assign start_pos    = head.start_pos;
  assign span_len     = head.span_len;
  assign error_cause  = head.error_cause;
  assign last_of_item = head.last_of_item;

  `STT_ASSERT_SAME(a_stall_only_when_held, clk, rst, in_stall, item_valid, "stall without a held beat")
  `STT_ASSERT_SAME(a_pair_kept_whole, clk, rst, out_valid && !last_of_item, fifo_status.count >= 2, "first token of a pair without its partner")
  `STT_ASSERT_NEXT(a_push_shows, clk, rst, advance && results.n != 2'd0, out_valid, "pushed token not presented")
  `STT_ASSERT_SAME(a_end_clean, clk, rst, out_valid && kind == stt_pkg::KIND_END, error_cause == stt_pkg::CAUSE_NONE && span_len == '0, "end token carries a cause or length")

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the SQL statement tokenizer against a token predictor.
module tb_top;

  localparam int POS_BITS     = stt_pkg::POS_BITS_DEFAULT;
  localparam int KEY_CHARS    = stt_pkg::KEY_CHARS_DEFAULT;
  localparam int MAX_POS      = (1 << POS_BITS) - 1;
  localparam int RANDOM_ITEMS = 650;
  localparam int HOLD_CYCLES  = 60;
  localparam int TAIL_CYCLES  = 16;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int REPORT_LIMIT = 30;

  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_END  = 1'b1;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_SPACE = " ";
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_A     = "a";
  localparam logic [7:0] CH_Z     = "z";
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_NINE  = "9";

  typedef enum logic [2:0] {LX_IDLE, LX_WORD, LX_NUM, LX_MINUS, LX_STR, LX_ERR} lex_mode_t;

  class token_scoreboard_t;
    stt_pkg::result_t expected_tokens[$];
    int               errors;
    int               tokens_checked;
    bit               kw_seen[16];
    string            kw_text[16];
    logic [7:0]       sym_chars[7];
    lex_mode_t        mode;
    int unsigned      pos_count;
    int unsigned      tok_start;
    int unsigned      nlet;
    logic [7:0]       word_buf[KEY_CHARS];

    function new();
      kw_text = '{"create", "database", "drop", "use", "table", "primary", "insert",
                  "values", "select", "from", "where", "delete", "update", "set", "int",
                  "string"};
      sym_chars = '{"*", ",", "(", ")", "=", "<", ">"};
      errors = 0;
      tokens_checked = 0;
      mode = LX_IDLE;
      pos_count = 0;
      tok_start = 0;
      nlet = 0;
      foreach (kw_seen[k]) kw_seen[k] = 1'b0;
    endfunction

    function bit is_lower(logic [7:0] c);
      return c >= CH_A && c <= CH_Z;
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function bit is_space(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
    endfunction

    function void push_token(logic [4:0] k, int unsigned p, int unsigned len,
                             logic [1:0] cause);
      stt_pkg::result_t t;
      t.kind         = k;
      t.start_pos    = 16'(p);
      t.span_len     = 16'(len);
      t.error_cause  = cause;
      t.last_of_item = 1'b0;
      expected_tokens = {expected_tokens, t};
    endfunction

    // Only the first KEY_CHARS letters are held, so a longer word is never a keyword.
    function logic [4:0] word_kind();
      bit hit;
      if (nlet > KEY_CHARS) return stt_pkg::KIND_IDENT;
      for (int k = 0; k < 16; k++) begin
        if (kw_text[k].len() == nlet) begin
          hit = 1'b1;
          for (int i = 0; i < nlet; i++)
            if (word_buf[i] != kw_text[k][i]) hit = 1'b0;
          if (hit) return 5'(k);
        end
      end
      return stt_pkg::KIND_IDENT;
    endfunction

    function void open_token(logic [7:0] c, int unsigned p);
      tok_start = p;
      if (is_space(c)) begin
        mode = LX_IDLE;
      end else if (is_lower(c)) begin
        word_buf[0] = c;
        nlet = 1;
        mode = LX_WORD;
      end else if (is_digit(c)) begin
        mode = LX_NUM;
      end else if (c == CH_MINUS) begin
        mode = LX_MINUS;
      end else if (c == CH_QUOTE) begin
        mode = LX_STR;
      end else begin
        mode = LX_ERR;
        for (int k = 0; k < 7; k++) begin
          if (sym_chars[k] == c) begin
            push_token(5'(stt_pkg::KIND_STAR + k), p, 1, stt_pkg::CAUSE_NONE);
            mode = LX_IDLE;
          end
        end
        if (mode == LX_ERR) push_token(stt_pkg::KIND_ERR, p, 0, stt_pkg::CAUSE_UNEXPECT);
      end
    endfunction

    // Predicts the tokens of one accepted beat; returns 1 when the beat is ignored.
    function bit note_beat(logic f, logic [7:0] c);
      int unsigned      p;
      int               n_before;
      bit               ignored;
      stt_pkg::result_t t;
      p = pos_count;
      n_before = expected_tokens.size();
      ignored = 1'b0;
      if (f == FUNC_END) begin
        case (mode)
          LX_WORD:  push_token(word_kind(), tok_start, p - tok_start, stt_pkg::CAUSE_NONE);
          LX_NUM:   push_token(stt_pkg::KIND_INT, tok_start, p - tok_start,
                               stt_pkg::CAUSE_NONE);
          LX_MINUS: push_token(stt_pkg::KIND_ERR, tok_start, 0, stt_pkg::CAUSE_UNEXPECT);
          LX_STR:   push_token(stt_pkg::KIND_ERR, tok_start, 0, stt_pkg::CAUSE_UNTERM);
          default:  ;
        endcase
        if (mode != LX_ERR && mode != LX_MINUS && mode != LX_STR)
          push_token(stt_pkg::KIND_END, p, 0, stt_pkg::CAUSE_NONE);
        mode = LX_IDLE;
        pos_count = 0;
        tok_start = 0;
      end else if (mode == LX_ERR) begin
        ignored = 1'b1;
      end else if (p >= MAX_POS) begin
        // The pending token, if any, is dropped in favour of the overflow error.
        push_token(stt_pkg::KIND_ERR, p, 0, stt_pkg::CAUSE_TOO_LONG);
        mode = LX_ERR;
      end else begin
        case (mode)
          LX_WORD: begin
            if (is_lower(c)) begin
              if (nlet < KEY_CHARS) word_buf[nlet] = c;
              if (nlet <= KEY_CHARS) nlet++;
            end else begin
              push_token(word_kind(), tok_start, p - tok_start, stt_pkg::CAUSE_NONE);
              open_token(c, p);
            end
          end
          LX_NUM: begin
            if (!is_digit(c)) begin
              push_token(stt_pkg::KIND_INT, tok_start, p - tok_start, stt_pkg::CAUSE_NONE);
              open_token(c, p);
            end
          end
          LX_MINUS: begin
            if (is_digit(c)) begin
              mode = LX_NUM;
            end else begin
              push_token(stt_pkg::KIND_ERR, tok_start, 0, stt_pkg::CAUSE_UNEXPECT);
              mode = LX_ERR;
            end
          end
          LX_STR: begin
            if (c == CH_QUOTE) begin
              push_token(stt_pkg::KIND_STR, tok_start, p - tok_start - 1,
                         stt_pkg::CAUSE_NONE);
              mode = LX_IDLE;
            end
          end
          default: open_token(c, p);
        endcase
        pos_count = p + 1;
      end
      if (expected_tokens.size() > n_before) begin
        t = expected_tokens.pop_back();
        t.last_of_item = 1'b1;
        expected_tokens = {expected_tokens, t};
      end
      return ignored;
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_token(stt_pkg::result_t got);
      stt_pkg::result_t want;
      if (expected_tokens.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: unexpected token, expected none, got kind %0d at %0d len %0d",
                   $time, got.kind, got.start_pos, got.span_len);
        return;
      end
      want = expected_tokens.pop_front();
      tokens_checked++;
      if (got.kind < stt_pkg::KIND_IDENT) kw_seen[got.kind[3:0]] = 1'b1;
      check_field("kind", 32'(want.kind), 32'(got.kind));
      check_field("start_pos", 32'(want.start_pos), 32'(got.start_pos));
      check_field("span_len", 32'(want.span_len), 32'(got.span_len));
      check_field("error_cause", 32'(want.error_cause), 32'(got.error_cause));
      check_field("last_of_item", 32'(want.last_of_item), 32'(got.last_of_item));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        func;
  logic [7:0]  char_in;
  logic        out_valid;
  logic        out_stall;
  logic [4:0]  kind;
  logic [15:0] start_pos;
  logic [15:0] span_len;
  logic [1:0]  error_cause;
  logic        last_of_item;

  token_scoreboard_t sb;
  bit                steady;
  bit                hold_req;
  int                holds_done;
  int                burst_left;
  int                beats_in;
  int                useful_items;
  int                statements;
  int                cycle_count;

  sql_statement_tokenizer_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .char_in      (char_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .start_pos    (start_pos),
    .span_len     (span_len),
    .error_cause  (error_cause),
    .last_of_item (last_of_item)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d tokens outstanding",
             cycle_count, sb.expected_tokens.size());
    $display("tb_top failed");
    $finish;
  end

  // Result side: checks every accepted token and stalls in phases of its own.
  initial begin : receiver
    stt_pkg::result_t got;
    int               stall_mode;
    int               mode_left;
    int               hold_left;
    out_stall <= 1'b0;
    stall_mode = 0;
    mode_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got.kind         = kind;
        got.start_pos    = start_pos;
        got.span_len     = span_len;
        got.error_cause  = error_cause;
        got.last_of_item = last_of_item;
        sb.check_token(got);
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
        holds_done++;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(10, 80);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // Offers one beat, waits for it to be taken and then perhaps leaves a gap.
  task automatic send_item(input logic f, input logic [7:0] c);
    int gap;
    in_valid <= 1'b1;
    func     <= f;
    char_in  <= c;
    do @(posedge clk); while (in_stall);
    beats_in++;
    if (!sb.note_beat(f, c)) useful_items++;
    if (f == FUNC_END) statements++;
    if (!steady) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 6);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(0, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(FUNC_BYTE, s[i]);
  endtask

  // The sender stops offering while it waits, so no beat is taken twice.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.expected_tokens.size() != 0) @(posedge clk);
  endtask

  // The receiver holds off while symbols keep coming, so the result queue
  // fills and the input side has to stall.
  task automatic squeeze();
    hold_req = 1'b1;
    steady = 1'b1;
    repeat (24) send_item(FUNC_BYTE, sb.sym_chars[$urandom_range(0, 6)]);
    send_item(FUNC_END, 8'($urandom_range(0, 255)));
    steady = 1'b0;
    wait_drained();
  endtask

  task automatic random_statement();
    logic [7:0] text[$];
    logic [7:0] ch;
    string      kw;
    int         pick;
    int         n_tok;
    n_tok = $urandom_range(1, 10);
    for (int t = 0; t < n_tok; t++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        kw = sb.kw_text[$urandom_range(0, 15)];
        for (int i = 0; i < kw.len(); i++) text = {text, kw[i]};
        // Sometimes a keyword grows into an identifier, at times past the held letters.
        if ($urandom_range(0, 4) == 0)
          repeat ($urandom_range(1, 4)) text = {text, 8'(CH_A + $urandom_range(0, 25))};
      end else if (pick < 48) begin
        repeat ($urandom_range(1, 12)) text = {text, 8'(CH_A + $urandom_range(0, 25))};
      end else if (pick < 62) begin
        if ($urandom_range(0, 2) == 0) text = {text, CH_MINUS};
        repeat ($urandom_range(1, 5)) text = {text, 8'(CH_ZERO + $urandom_range(0, 9))};
      end else if (pick < 72) begin
        text = {text, CH_QUOTE};
        repeat ($urandom_range(0, 6)) begin
          ch = 8'($urandom_range(0, 255));
          text = {text, (ch == CH_QUOTE) ? CH_SPACE : ch};
        end
        text = {text, CH_QUOTE};
      end else if (pick < 94) begin
        text = {text, sb.sym_chars[$urandom_range(0, 6)]};
      end else if (pick < 97) begin
        text = {text, CH_MINUS};
      end else begin
        text = {text, 8'($urandom_range(0, 255))};
      end
      if ($urandom_range(0, 3) != 0) begin
        repeat ($urandom_range(1, 2)) begin
          case ($urandom_range(0, 3))
            0: text = {text, CH_SPACE};
            1: text = {text, CH_TAB};
            2: text = {text, CH_LF};
            default: text = {text, CH_CR};
          endcase
        end
      end
    end
    if ($urandom_range(0, 19) == 0) begin
      text = {text, CH_QUOTE};
      text = {text, CH_A};
    end
    foreach (text[i]) send_item(FUNC_BYTE, text[i]);
    send_item(FUNC_END, 8'($urandom_range(0, 255)));
  endtask

  initial begin : stimulus
    int n_rand;
    sb = new();
    rst      <= 1'b1;
    in_valid <= 1'b0;
    func     <= FUNC_BYTE;
    char_in  <= 8'h00;
    steady = 1'b0;
    hold_req = 1'b0;
    holds_done = 0;
    burst_left = 0;
    beats_in = 0;
    useful_items = 0;
    statements = 0;
    n_rand = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Long word, symbol and a negative number flushed by the end beat.
    send_text("databasex<-7");
    send_item(FUNC_END, 8'hFF);
    send_text("\"ab");
    send_item(FUNC_END, 8'h00);
    send_item(FUNC_BYTE, CH_MINUS);
    send_item(FUNC_END, 8'h00);
    // Lone minus, then a byte that the error state ignores.
    send_text("-x");
    send_item(FUNC_BYTE, 8'hFF);
    send_item(FUNC_END, 8'h00);
    send_item(FUNC_BYTE, 8'h00);
    send_item(FUNC_END, 8'h00);
    send_item(FUNC_END, 8'h00);
    squeeze();

    useful_items = 0;
    while (useful_items < RANDOM_ITEMS) begin
      random_statement();
      n_rand++;
      if (n_rand % 12 == 0) squeeze();
    end
    if (burst_left != 0 || steady) in_valid <= 1'b0;

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.expected_tokens.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d tokens expected, none arrived; first kind %0d at %0d", $time,
               sb.expected_tokens.size(), sb.expected_tokens[0].kind,
               sb.expected_tokens[0].start_pos);
    end
    $display("Sent %0d beats in %0d statements, with symbol bursts against receiver hold-offs",
             beats_in, statements);
    $display("Checked %0d tokens, %0d of 16 keywords seen, %0d receiver hold-offs",
             sb.tokens_checked, sb.kw_seen.sum() with (int'(item)), holds_done);
    if (sb.errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/stt_pkg.sv
src/stt_lexer.sv
src/stt_result_fifo.sv
src/sql_statement_tokenizer_top.sv
tb/tb_top.sv
